@@ sv/load_cell_adc_serial_reader_core_defines.svh @@
// Assertion macros used by the RTL top level.
`ifndef LOAD_CELL_ADC_SERIAL_READER_CORE_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LCASR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LCASR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCASR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LCASR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/lcasr_pkg.sv @@
package lcasr_pkg;

	localparam int SAMPLE_BITS = 24;

	typedef enum logic [2:0] {
		KIND_TICK       = 3'd0,
		KIND_MEASURE    = 3'd1,
		KIND_TARE       = 3'd2,
		KIND_SET_OFFSET = 3'd3,
		KIND_POWER_DOWN = 3'd4,
		KIND_POWER_UP   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		REG_GAIN_PULSES   = 2'd0,
		REG_SAMPLE_COUNT  = 2'd1,
		REG_TIMEOUT_TICKS = 2'd2,
		REG_GAP_TICKS     = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_HIGH  = 3'd2,
		PH_LOW   = 3'd3,
		PH_GHIGH = 3'd4,
		PH_GLOW  = 3'd5,
		PH_GAP   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		UOP_NOP      = 3'd0,
		UOP_ACCEPT   = 3'd1,
		UOP_TICK     = 3'd2,
		UOP_DIV_INIT = 3'd3,
		UOP_DIV_STEP = 3'd4,
		UOP_DIV_FIX  = 3'd5,
		UOP_TARE     = 3'd6,
		UOP_EMIT     = 3'd7
	} uop_t;

	typedef enum logic [2:0] {
		COND_NONE        = 3'd0,
		COND_NO_BEAT     = 3'd1,
		COND_NOT_FINISH  = 3'd2,
		COND_DIV_MORE    = 3'd3,
		COND_OUT_BLOCKED = 3'd4
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_TICK     = 3'd1;
	localparam step_t STEP_DIV_INIT = 3'd2;
	localparam step_t STEP_DIV_LOOP = 3'd3;
	localparam step_t STEP_DIV_FIX  = 3'd4;
	localparam step_t STEP_TARE     = 3'd5;
	localparam step_t STEP_EMIT     = 3'd6;

	// jump to target when cond holds, else go to next
	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
		step_t next;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic finish;
		logic div_more;
		logic out_blocked;
	} dp_status_t;

	function automatic ctrl_word_t ucode_rom(input step_t s);
		ctrl_word_t w;
		unique case (s)
			STEP_IDLE:     w = '{UOP_ACCEPT,   COND_NO_BEAT,     STEP_IDLE,     STEP_TICK};
			STEP_TICK:     w = '{UOP_TICK,     COND_NOT_FINISH,  STEP_EMIT,     STEP_DIV_INIT};
			STEP_DIV_INIT: w = '{UOP_DIV_INIT, COND_NONE,        STEP_IDLE,     STEP_DIV_LOOP};
			STEP_DIV_LOOP: w = '{UOP_DIV_STEP, COND_DIV_MORE,    STEP_DIV_LOOP, STEP_DIV_FIX};
			STEP_DIV_FIX:  w = '{UOP_DIV_FIX,  COND_NONE,        STEP_IDLE,     STEP_TARE};
			STEP_TARE:     w = '{UOP_TARE,     COND_NONE,        STEP_IDLE,     STEP_EMIT};
			STEP_EMIT:     w = '{UOP_EMIT,     COND_OUT_BLOCKED, STEP_EMIT,     STEP_IDLE};
			default:       w = '{UOP_NOP,      COND_NONE,        STEP_IDLE,     STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/lcasr_if.sv @@
interface lcasr_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic               dout_level;
	logic signed [23:0] offset_value;

	modport source(output valid, kind, dout_level, offset_value, input ready);
	modport sink(input valid, kind, dout_level, offset_value, output ready);
endinterface

interface lcasr_out_if;
	logic               valid;
	logic               ready;
	logic               sck_level;
	logic               busy_res;
	logic               done_res;
	logic signed [23:0] average;
	logic signed [24:0] reading;
	logic [7:0]         good_samples;
	logic               powered_down;

	modport source(output valid, sck_level, busy_res, done_res, average, reading,
		good_samples, powered_down, input ready);
	modport sink(input valid, sck_level, busy_res, done_res, average, reading,
		good_samples, powered_down, output ready);
endinterface

@@ sv/lcasr_seq.sv @@
module lcasr_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcasr_pkg::dp_status_t status,
	output lcasr_pkg::uop_t       op
);

	lcasr_pkg::step_t      step_q;
	lcasr_pkg::ctrl_word_t cw;
	logic                  hit;

	assign cw = lcasr_pkg::ucode_rom(step_q);
	assign op = cw.op;

	always_comb begin
		unique case (cw.cond)
			lcasr_pkg::COND_NONE:        hit = 1'b0;
			lcasr_pkg::COND_NO_BEAT:     hit = !status.in_valid;
			lcasr_pkg::COND_NOT_FINISH:  hit = !status.finish;
			lcasr_pkg::COND_DIV_MORE:    hit = status.div_more;
			lcasr_pkg::COND_OUT_BLOCKED: hit = status.out_blocked;
			default:                     hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lcasr_pkg::STEP_IDLE;
		end else begin
			step_q <= hit ? cw.target : cw.next;
		end
	end

endmodule

@@ sv/lcasr_dp.sv @@
module lcasr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcasr_pkg::uop_t       op,
	output lcasr_pkg::dp_status_t status,
	lcasr_in_if.sink              cmd,
	lcasr_out_if.source           res,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [16:0]           cfg_wdata
);

	// configuration
	logic [1:0]  gain_q;
	logic [7:0]  count_q;
	logic [16:0] timeout_q;
	logic [15:0] gap_q;

	// latched beat
	logic [2:0]  kind_q;
	logic        dout_q;
	logic [23:0] offv_q;

	// reader state
	lcasr_pkg::phase_t phase_q, n_phase;
	logic [4:0]  bit_q, n_bit, bit_inc;
	logic [23:0] shift_q, n_shift;
	logic [16:0] wait_q, n_wait;
	logic [7:0]  smp_q, n_smp;
	logic [7:0]  good_q, n_good;
	logic [31:0] sum_q, n_sum;
	logic [23:0] offset_q, n_off;
	logic        tare_q, n_tare;
	logic        sck_q, n_sck;
	logic        sleep_q, n_sleep;
	logic        fin;
	logic        done_q;

	// divider
	logic        neg_q;
	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [4:0]  dcnt_q;
	logic [8:0]  trial;
	logic [8:0]  trial_sub;
	logic        trial_ge;
	logic [31:0] quo_signed;
	logic [23:0] avg_q;
	logic [24:0] rd;

	logic out_valid_q;
	logic out_load;

	assign cmd.ready = (op == lcasr_pkg::UOP_ACCEPT);

	assign status.in_valid    = cmd.valid;
	assign status.finish      = fin;
	assign status.div_more    = (dcnt_q != 5'd0);
	assign status.out_blocked = out_valid_q && !res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 2'd1;
			count_q   <= 8'd1;
			timeout_q <= 17'd100000;
			gap_q     <= 16'd2000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcasr_pkg::REG_GAIN_PULSES:   gain_q    <= cfg_wdata[1:0];
				lcasr_pkg::REG_SAMPLE_COUNT:  count_q   <= cfg_wdata[7:0];
				lcasr_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg_wdata;
				lcasr_pkg::REG_GAP_TICKS:     gap_q     <= cfg_wdata[15:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == lcasr_pkg::UOP_ACCEPT && cmd.valid) begin
			kind_q <= cmd.kind;
			dout_q <= cmd.dout_level;
			offv_q <= cmd.offset_value;
		end
	end

	assign bit_inc = bit_q + 5'd1;

	// one half-bit tick of the reader
	always_comb begin
		n_phase = phase_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_wait  = wait_q;
		n_smp   = smp_q;
		n_good  = good_q;
		n_sum   = sum_q;
		n_off   = offset_q;
		n_tare  = tare_q;
		n_sck   = sck_q;
		n_sleep = sleep_q;
		fin     = 1'b0;

		priority if (kind_q == lcasr_pkg::KIND_SET_OFFSET) begin
			n_off = offv_q;
		end else if (kind_q == lcasr_pkg::KIND_POWER_DOWN) begin
			n_sleep = 1'b1;
			n_sck   = 1'b1;
			n_phase = lcasr_pkg::PH_IDLE;
		end else if (kind_q == lcasr_pkg::KIND_POWER_UP) begin
			n_sleep = 1'b0;
			n_sck   = 1'b0;
		end else begin
		end

		if ((kind_q == lcasr_pkg::KIND_MEASURE || kind_q == lcasr_pkg::KIND_TARE)
				&& n_phase == lcasr_pkg::PH_IDLE && !n_sleep) begin
			n_phase = lcasr_pkg::PH_WAIT;
			n_wait  = '0;
			n_bit   = '0;
			n_shift = '0;
			n_smp   = '0;
			n_good  = '0;
			n_sum   = '0;
			n_tare  = (kind_q == lcasr_pkg::KIND_TARE);
			n_sck   = 1'b0;
		end else if (!n_sleep && n_phase != lcasr_pkg::PH_IDLE) begin
			unique case (n_phase)
				lcasr_pkg::PH_WAIT: begin
					n_sck = 1'b0;
					if (!dout_q) begin
						n_phase = lcasr_pkg::PH_HIGH;
						n_bit   = '0;
						n_shift = '0;
					end else if (wait_q >= timeout_q) begin
						n_smp   = smp_q + 8'd1;
						n_phase = lcasr_pkg::PH_GAP;
						n_wait  = '0;
					end else begin
						n_wait = wait_q + 17'd1;
					end
				end
				lcasr_pkg::PH_HIGH: begin
					n_sck   = 1'b1;
					n_shift = {shift_q[22:0], dout_q};
					n_phase = lcasr_pkg::PH_LOW;
				end
				lcasr_pkg::PH_LOW: begin
					n_sck = 1'b0;
					if (bit_inc >= 5'(lcasr_pkg::SAMPLE_BITS)) begin
						n_bit   = '0;
						n_phase = lcasr_pkg::PH_GHIGH;
					end else begin
						n_bit   = bit_inc;
						n_phase = lcasr_pkg::PH_HIGH;
					end
				end
				lcasr_pkg::PH_GHIGH: begin
					n_sck   = 1'b1;
					n_phase = lcasr_pkg::PH_GLOW;
				end
				lcasr_pkg::PH_GLOW: begin
					n_sck = 1'b0;
					n_bit = bit_inc;
					if (bit_inc >= {3'b000, gain_q}) begin
						if (shift_q != 24'd0) begin
							n_sum  = sum_q + {{8{shift_q[23]}}, shift_q};
							n_good = good_q + 8'd1;
						end
						n_smp   = smp_q + 8'd1;
						n_phase = lcasr_pkg::PH_GAP;
						n_wait  = '0;
					end else begin
						n_phase = lcasr_pkg::PH_GHIGH;
					end
				end
				lcasr_pkg::PH_GAP: begin
					n_sck = 1'b0;
					if (wait_q >= {1'b0, gap_q}) begin
						if (smp_q >= count_q) begin
							fin     = 1'b1;
							n_phase = lcasr_pkg::PH_IDLE;
						end else begin
							n_phase = lcasr_pkg::PH_WAIT;
							n_wait  = '0;
						end
					end else begin
						n_wait = wait_q + 17'd1;
					end
				end
				default: n_phase = lcasr_pkg::PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lcasr_pkg::PH_IDLE;
			bit_q    <= '0;
			shift_q  <= '0;
			wait_q   <= '0;
			smp_q    <= '0;
			good_q   <= '0;
			sum_q    <= '0;
			offset_q <= '0;
			tare_q   <= 1'b0;
			sck_q    <= 1'b0;
			sleep_q  <= 1'b0;
			done_q   <= 1'b0;
		end else if (op == lcasr_pkg::UOP_TICK) begin
			phase_q  <= n_phase;
			bit_q    <= n_bit;
			shift_q  <= n_shift;
			wait_q   <= n_wait;
			smp_q    <= n_smp;
			good_q   <= n_good;
			sum_q    <= n_sum;
			offset_q <= n_off;
			tare_q   <= n_tare;
			sck_q    <= n_sck;
			sleep_q  <= n_sleep;
			done_q   <= fin;
		end else if (op == lcasr_pkg::UOP_TARE && tare_q) begin
			offset_q <= avg_q;
		end
	end

	// restoring divide of |sum| by good count, one quotient bit per step
	assign trial     = {rem_q, quo_q[31]};
	assign trial_ge  = (trial >= {1'b0, good_q});
	assign trial_sub = trial - {1'b0, good_q};
	assign quo_signed = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (op == lcasr_pkg::UOP_DIV_INIT) begin
			dcnt_q <= 5'd31;
		end else if (op == lcasr_pkg::UOP_DIV_STEP) begin
			dcnt_q <= dcnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			lcasr_pkg::UOP_DIV_INIT: begin
				neg_q <= sum_q[31];
				quo_q <= sum_q[31] ? (32'd0 - sum_q) : sum_q;
				rem_q <= '0;
			end
			lcasr_pkg::UOP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_sub[7:0] : trial[7:0];
				quo_q <= {quo_q[30:0], trial_ge};
			end
			lcasr_pkg::UOP_DIV_FIX: begin
				avg_q <= (good_q == 8'd0) ? 24'd0 : quo_signed[23:0];
			end
			default: begin
			end
		endcase
	end

	assign rd = {avg_q[23], avg_q} - {offset_q[23], offset_q};

	assign out_load = (op == lcasr_pkg::UOP_EMIT) && !(out_valid_q && !res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.sck_level    <= sck_q;
			res.busy_res     <= (phase_q != lcasr_pkg::PH_IDLE);
			res.done_res     <= done_q;
			res.average      <= done_q ? avg_q : 24'd0;
			res.reading      <= done_q ? rd : 25'd0;
			res.good_samples <= done_q ? good_q : 8'd0;
			res.powered_down <= sleep_q;
		end
	end

	assign res.valid = out_valid_q;

endmodule

@@ sv/load_cell_adc_serial_reader_core.sv @@
// Bit-banged reader for a load-cell converter. Each input beat is one half-bit tick carrying
// the data pin level and a command (tick, measure, tare, set offset, power down, power up);
// each beat yields exactly one result beat with the clock pin level to drive for that tick,
// busy and power-down flags, and, on the tick that ends a measure or tare job, the truncated
// mean of the good samples, that mean minus the stored offset, and the good sample count.
// A small microcode sequencer steps a shared datapath: a beat that ends no job runs accept,
// tick update and result register load; a beat that ends a job also runs, before the load,
// the 32-step restoring divider that forms the mean, its sign fix and the tare step. The next
// beat is taken as soon as the result is in the output register. Configuration is written
// through cfg_we/cfg_index/cfg_wdata and takes effect on the next tick.
`include "load_cell_adc_serial_reader_core_defines.svh"

module load_cell_adc_serial_reader_core (
	input  logic        clk,
	input  logic        arst_n,
	lcasr_in_if.sink    cmd,
	lcasr_out_if.source res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);

	lcasr_pkg::uop_t       op;
	lcasr_pkg::dp_status_t status;

	lcasr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	lcasr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.cmd       (cmd),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	`LCASR_ASSERT_NEXT(a_one_beat_at_a_time, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready, "beat accepted while previous in work")
	`LCASR_ASSERT_NOW(a_done_not_busy, clk, arst_n, res.valid && res.done_res, !res.busy_res, "job done but still busy")
	`LCASR_ASSERT_NOW(a_idle_fields_zero, clk, arst_n, res.valid && !res.done_res, res.average == 24'sd0 && res.reading == 25'sd0 && res.good_samples == 8'd0, "result fields set without done")
	`LCASR_ASSERT_NOW(a_sleep_clock_high, clk, arst_n, res.valid && res.powered_down, res.sck_level, "clock low while powered down")

endmodule
